/* sv/fmch_pkg.sv */
package fmch_pkg;

  // Fan level, as driven on applied_mode.
  typedef enum logic [1:0] {
    LVL_STOP   = 2'd0,
    LVL_ECO    = 2'd1,
    LVL_NORMAL = 2'd2,
    LVL_FORCED = 2'd3
  } fan_level_e;

  // User mode codes; codes above MODE_AUTO act as stopped.
  localparam logic [2:0] MODE_STOP   = 3'd0;
  localparam logic [2:0] MODE_FORCED = 3'd3;
  localparam logic [2:0] MODE_AUTO   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_USER_MODE      = 3'd0;
  localparam logic [2:0] CFG_ECO_ON_TEMP    = 3'd1;
  localparam logic [2:0] CFG_NORMAL_ON_TEMP = 3'd2;
  localparam logic [2:0] CFG_FORCED_ON_TEMP = 3'd3;
  localparam logic [2:0] CFG_HYSTERESIS     = 3'd4;
  localparam logic [2:0] CFG_ECO_PERCENT    = 3'd5;
  localparam logic [2:0] CFG_NORMAL_PERCENT = 3'd6;
  localparam logic [2:0] CFG_FORCED_PERCENT = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Temperatures in 1/16 degC.
  localparam logic signed [15:0] TEMP_MIN      = -16'sd880;
  localparam logic signed [15:0] TEMP_MAX      = 16'sd2000;
  localparam logic signed [15:0] TEMP_POWER_ON = 16'sd1360;

  localparam logic [11:0] HYST_DEFAULT = 12'd32;
  localparam logic [6:0]  STOP_PERCENT = 7'd0;
  localparam logic [6:0]  MAX_PERCENT  = 7'd100;

  typedef struct packed {
    logic [2:0]         user_mode;
    logic signed [11:0] eco_on_temp;
    logic signed [11:0] normal_on_temp;
    logic signed [11:0] forced_on_temp;
    logic [11:0]        hysteresis;
    logic [6:0]         eco_percent;
    logic [6:0]         normal_percent;
    logic [6:0]         forced_percent;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] last_temp;
    logic               last_temp_valid;
    fan_level_e         current_mode;
    logic [6:0]         last_percent;
  } state_t;

  typedef struct packed {
    logic [6:0]         fan_percent;
    fan_level_e         applied_mode;
    logic               mode_changed;
    logic signed [11:0] temp_used;
    logic               temp_known;
    logic               reading_rejected;
  } result_t;

endpackage

/* sv/fan_mode_controller_hysteresis_unit.sv */
// Fan mode controller with hysteresis.
// A reading transferred in is held in the input register; its result is offered
// by the result register. Throughput: one reading per cycle unless downstream
// stalls, set by the single compare-and-select pass between the two registers.
// Reset (asynchronous, active low) restores the default configuration, forgets
// the last temperature and puts the fan level at stopped with zero percent.
module fan_mode_controller_hysteresis_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [fmch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fmch_pkg::CfgDataW-1:0] cfg_wdata_i,

  // Reading channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            temp_reading_i,
  input  logic                          reading_ok_i,

  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [6:0]                    fan_percent_o,
  output logic [1:0]                    applied_mode_o,
  output logic                          mode_changed_o,
  output logic signed [11:0]            temp_used_o,
  output logic                          temp_known_o,
  output logic                          reading_rejected_o
);

  fmch_pkg::cfg_t    cfg;
  fmch_pkg::state_t  state_d, state_q;
  fmch_pkg::result_t result_d, result_q;

  logic               in_valid_d, in_valid_q;
  logic signed [15:0] temp_q;
  logic               ok_q;
  logic               out_valid_d, out_valid_q;
  logic               advance;
  logic               in_load;

  fmch_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The result register moves whenever it is empty or its transfer completes
  // this cycle. The input register then hands its reading to the core, and
  // can take a new reading in the same cycle, so the pipe never bubbles
  // unless the downstream side stalls.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (!in_valid_q || advance) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      temp_q <= temp_reading_i;
      ok_q   <= reading_ok_i;
    end
  end

  // The core sees the held reading together with the controller state left
  // by the previous reading, so state and result are settled in one pass.
  fmch_core u_core (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .temp_reading_i (temp_q),
    .reading_ok_i   (ok_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.last_temp       <= '0;
      state_q.last_temp_valid <= 1'b0;
      state_q.current_mode    <= fmch_pkg::LVL_STOP;
      state_q.last_percent    <= fmch_pkg::STOP_PERCENT;
    end else if (advance && in_valid_q) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign fan_percent_o      = result_q.fan_percent;
  assign applied_mode_o     = result_q.applied_mode;
  assign mode_changed_o     = result_q.mode_changed;
  assign temp_used_o        = result_q.temp_used;
  assign temp_known_o       = result_q.temp_known;
  assign reading_rejected_o = result_q.reading_rejected;

endmodule

/* sv/fmch_cfg_regs.sv */
module fmch_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fmch_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fmch_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output fmch_pkg::cfg_t                    cfg_o
);

  fmch_pkg::cfg_t cfg_d, cfg_q;
  logic [6:0]     pct_sat;

  // Percent writes whose low seven bits exceed the maximum saturate; the upper data bits are ignored.
  assign pct_sat = (cfg_wdata_i[6:0] > fmch_pkg::MAX_PERCENT) ?
                   fmch_pkg::MAX_PERCENT : cfg_wdata_i[6:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fmch_pkg::CFG_USER_MODE:      cfg_d.user_mode      = cfg_wdata_i[2:0];
        fmch_pkg::CFG_ECO_ON_TEMP:    cfg_d.eco_on_temp    = cfg_wdata_i;
        fmch_pkg::CFG_NORMAL_ON_TEMP: cfg_d.normal_on_temp = cfg_wdata_i;
        fmch_pkg::CFG_FORCED_ON_TEMP: cfg_d.forced_on_temp = cfg_wdata_i;
        fmch_pkg::CFG_HYSTERESIS: begin
          // A zero hysteresis write is not stored; use the default.
          cfg_d.hysteresis = (cfg_wdata_i == '0) ? fmch_pkg::HYST_DEFAULT : cfg_wdata_i;
        end
        fmch_pkg::CFG_ECO_PERCENT:    cfg_d.eco_percent    = pct_sat;
        fmch_pkg::CFG_NORMAL_PERCENT: cfg_d.normal_percent = pct_sat;
        fmch_pkg::CFG_FORCED_PERCENT: cfg_d.forced_percent = pct_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.user_mode      <= fmch_pkg::MODE_AUTO;
      cfg_q.eco_on_temp    <= 12'sd560;
      cfg_q.normal_on_temp <= 12'sd720;
      cfg_q.forced_on_temp <= 12'sd880;
      cfg_q.hysteresis     <= fmch_pkg::HYST_DEFAULT;
      cfg_q.eco_percent    <= 7'd40;
      cfg_q.normal_percent <= 7'd70;
      cfg_q.forced_percent <= 7'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/fmch_core.sv */
module fmch_core (
  input  fmch_pkg::cfg_t       cfg_i,
  input  fmch_pkg::state_t     state_i,
  input  logic signed [15:0]   temp_reading_i,
  input  logic                 reading_ok_i,
  output fmch_pkg::state_t     state_o,
  output fmch_pkg::result_t    result_o
);

  logic                  rejected;
  logic signed [11:0]    new_temp;
  logic                  known;
  logic signed [11:0]    used;
  fmch_pkg::fan_level_e  prev;
  fmch_pkg::fan_level_e  raw;
  fmch_pkg::fan_level_e  mode;
  logic signed [11:0]    prev_on;
  logic signed [13:0]    prev_off;
  logic signed [13:0]    used_ext;
  logic                  hold;
  logic [6:0]            pct;
  logic [6:0]            mode_pct;

  assign rejected = !reading_ok_i ||
                    (temp_reading_i < fmch_pkg::TEMP_MIN) ||
                    (temp_reading_i > fmch_pkg::TEMP_MAX) ||
                    (temp_reading_i == fmch_pkg::TEMP_POWER_ON);

  // An accepted reading lies within -880..2000 and fits 12 signed bits.
  assign new_temp = rejected ? state_i.last_temp : temp_reading_i[11:0];
  assign known    = !rejected || state_i.last_temp_valid;
  assign used     = known ? new_temp : '0;
  assign prev     = state_i.current_mode;

  // Highest level whose switch-on threshold is reached.
  always_comb begin
    if (used >= cfg_i.forced_on_temp) begin
      raw = fmch_pkg::LVL_FORCED;
    end else if (used >= cfg_i.normal_on_temp) begin
      raw = fmch_pkg::LVL_NORMAL;
    end else if (used >= cfg_i.eco_on_temp) begin
      raw = fmch_pkg::LVL_ECO;
    end else begin
      raw = fmch_pkg::LVL_STOP;
    end
  end

  always_comb begin
    case (prev)
      fmch_pkg::LVL_FORCED: prev_on = cfg_i.forced_on_temp;
      fmch_pkg::LVL_NORMAL: prev_on = cfg_i.normal_on_temp;
      default:              prev_on = cfg_i.eco_on_temp;
    endcase
  end

  assign prev_off = {{2{prev_on[11]}}, prev_on} - $signed({2'b00, cfg_i.hysteresis});
  assign used_ext = {{2{used[11]}}, used};
  assign hold     = (prev > raw) && (used_ext > prev_off);

  always_comb begin
    mode = prev;
    if (cfg_i.user_mode == fmch_pkg::MODE_AUTO) begin
      if (known) begin
        mode = hold ? prev : raw;
      end
    end else if (cfg_i.user_mode <= fmch_pkg::MODE_FORCED) begin
      mode = fmch_pkg::fan_level_e'(cfg_i.user_mode[1:0]);
    end else begin
      mode = fmch_pkg::LVL_STOP;
    end
  end

  always_comb begin
    case (mode)
      fmch_pkg::LVL_ECO:    mode_pct = cfg_i.eco_percent;
      fmch_pkg::LVL_NORMAL: mode_pct = cfg_i.normal_percent;
      fmch_pkg::LVL_FORCED: mode_pct = cfg_i.forced_percent;
      default:              mode_pct = fmch_pkg::STOP_PERCENT;
    endcase
  end

  always_comb begin
    pct = state_i.last_percent;
    if (cfg_i.user_mode == fmch_pkg::MODE_AUTO) begin
      if (known) begin
        pct = mode_pct;
      end else if (prev == fmch_pkg::LVL_STOP) begin
        pct = fmch_pkg::STOP_PERCENT;
      end
    end else if (cfg_i.user_mode <= fmch_pkg::MODE_FORCED) begin
      pct = mode_pct;
    end else begin
      pct = fmch_pkg::STOP_PERCENT;
    end
  end

  always_comb begin
    state_o.last_temp       = new_temp;
    state_o.last_temp_valid = known;
    state_o.current_mode    = mode;
    state_o.last_percent    = pct;

    result_o.fan_percent      = pct;
    result_o.applied_mode     = mode;
    result_o.mode_changed     = (mode != prev);
    result_o.temp_used        = used;
    result_o.temp_known       = known;
    result_o.reading_rejected = rejected;
  end

endmodule
